// ----- hw/rtl/sled_pkg.sv -----
`default_nettype none

package sled_pkg;

  localparam int unsigned BitsPerLed    = 24;
  localparam int unsigned MaxLatchSlots = 64;

  localparam int unsigned SlotW = 13;
  localparam int unsigned SizeW = 5;
  localparam int unsigned DutyW = 8;
  localparam int unsigned CntW  = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [SizeW-1:0] RowsDefault  = 5'd8;
  localparam logic [SizeW-1:0] ColsDefault  = 5'd8;
  localparam logic [DutyW-1:0] DutyOneDefault  = 8'd60;
  localparam logic [DutyW-1:0] DutyZeroDefault = 8'd30;
  // Latch pulse length is held as its final slot number (count - 1).
  localparam logic [CntW-1:0]  LatchLastDefault = 6'd49;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS      = 3'd0,
    CFG_COLS      = 3'd1,
    CFG_DUTY_ONE  = 3'd2,
    CFG_DUTY_ZERO = 3'd3,
    CFG_LATCH     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_LATCH = 2'd1,
    KIND_FAULT = 2'd2
  } kind_e;

  // Effective (already clamped) configuration.
  typedef struct packed {
    logic [SizeW-1:0] rows;
    logic [SizeW-1:0] cols;
    logic [DutyW-1:0] duty_one;
    logic [DutyW-1:0] duty_zero;
    logic [CntW-1:0]  latch_last;
  } cfg_t;

  typedef struct packed {
    kind_e                 kind;
    logic [SlotW-1:0]      base;
    logic [CntW-1:0]       last_n;
    logic [BitsPerLed-1:0] word;
  } job_t;

  typedef struct packed {
    logic [SlotW-1:0] slot_index;
    logic [DutyW-1:0] duty;
    logic             error;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sled_if.sv -----
`default_nettype none

interface sled_pix_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] row;
  logic [3:0] column;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] blue;

  modport source (output valid, opcode, row, column, green, red, blue, input ready);
  modport sink   (input valid, opcode, row, column, green, red, blue, output ready);
endinterface

interface sled_res_if;
  logic        valid;
  logic        ready;
  logic [12:0] slot_index;
  logic [7:0]  duty;
  logic        error;
  logic        last;

  modport source (output valid, slot_index, duty, error, last, input ready);
  modport sink   (input valid, slot_index, duty, error, last, output ready);
endinterface

interface sled_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sled_decode.sv -----
`default_nettype none

module sled_decode
  import sled_pkg::*;
(
  input  cfg_t       cfg_i,
  input  logic       opcode_i,
  input  logic [3:0] row_i,
  input  logic [3:0] column_i,
  input  logic [7:0] green_i,
  input  logic [7:0] red_i,
  input  logic [7:0] blue_i,
  output job_t       job_o
);

  logic [SizeW-1:0] row_ext;
  logic [SizeW-1:0] col_ext;
  logic [SizeW-1:0] pos;
  logic [9:0]       led;
  logic [9:0]       area;
  logic [14:0]      led_x24;
  logic [14:0]      area_x24;
  logic             outside;

  assign row_ext = {1'b0, row_i};
  assign col_ext = {1'b0, column_i};

  // Odd rows run right to left.
  assign pos  = row_i[0] ? (cfg_i.cols - 5'd1 - col_ext) : col_ext;
  assign led  = 10'(row_ext * cfg_i.cols) + {5'd0, pos};
  assign area = 10'(cfg_i.rows * cfg_i.cols);

  // x24 as x16 + x8
  assign led_x24  = {1'b0, led, 4'd0} + {2'd0, led, 3'd0};
  assign area_x24 = {1'b0, area, 4'd0} + {2'd0, area, 3'd0};

  assign outside = (row_ext >= cfg_i.rows) || (col_ext >= cfg_i.cols);

  always_comb begin
    job_o.word = {green_i, red_i, blue_i};
    if (opcode_i) begin
      job_o.kind   = KIND_LATCH;
      job_o.base   = area_x24[SlotW-1:0];
      job_o.last_n = cfg_i.latch_last;
    end else if (outside) begin
      job_o.kind   = KIND_FAULT;
      job_o.base   = '0;
      job_o.last_n = '0;
    end else begin
      job_o.kind   = KIND_PIXEL;
      job_o.base   = led_x24[SlotW-1:0];
      job_o.last_n = CntW'(BitsPerLed - 1);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/serpentine_led_bit_encoder_top.sv -----
// A pixel word is held in the job register, each result word in the result register.
// One result word per cycle while the receiver is ready; a pixel gives 24 words, a
// latch pulse its configured slot count (1..64), an out-of-range pixel a single one.
// A new pixel word is taken in the cycle its predecessor hands over its final result.
// Reset (rst_ni low, asynchronous) empties the pipeline and restores register defaults.
`default_nettype none

module serpentine_led_bit_encoder_top
  import sled_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 16,
  parameter int unsigned MAX_COLUMNS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sled_pix_if.sink    pix_i,
  sled_cfg_if.sink    cfg_i,
  sled_res_if.source  res_o
);

  // Size registers hold values already clamped to the matrix limits.
  localparam int unsigned LimitW = 7;
  localparam logic [SizeW-1:0] RowsReset =
    (int'(RowsDefault) > MAX_ROWS) ? SizeW'(MAX_ROWS) : RowsDefault;
  localparam logic [SizeW-1:0] ColsReset =
    (int'(ColsDefault) > MAX_COLUMNS) ? SizeW'(MAX_COLUMNS) : ColsDefault;

  // ---------------------------------------------------------------------------
  // Configuration store: always ready, clamp on write so the datapath never
  // sees an out-of-range size or latch length.
  // ---------------------------------------------------------------------------
  cfg_t cfg_q, cfg_d;
  logic cfg_wr;
  logic [SizeW-1:0] wr_size;
  logic [6:0]       wr_latch;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign wr_size     = cfg_i.data[SizeW-1:0];
  assign wr_latch    = cfg_i.data[6:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_ROWS: begin
          cfg_d.rows = ({2'd0, wr_size} > LimitW'(MAX_ROWS)) ? SizeW'(MAX_ROWS) : wr_size;
        end
        CFG_COLS: begin
          cfg_d.cols = ({2'd0, wr_size} > LimitW'(MAX_COLUMNS)) ?
                       SizeW'(MAX_COLUMNS) : wr_size;
        end
        CFG_DUTY_ONE:  cfg_d.duty_one  = cfg_i.data;
        CFG_DUTY_ZERO: cfg_d.duty_zero = cfg_i.data;
        CFG_LATCH: begin
          // zero counts as one slot, anything above the maximum saturates
          if (wr_latch == 7'd0) begin
            cfg_d.latch_last = '0;
          end else if (wr_latch > 7'(MaxLatchSlots)) begin
            cfg_d.latch_last = CntW'(MaxLatchSlots - 1);
          end else begin
            cfg_d.latch_last = CntW'(wr_latch - 7'd1);
          end
        end
        default: ;  // unused indexes drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows       <= RowsReset;
      cfg_q.cols       <= ColsReset;
      cfg_q.duty_one   <= DutyOneDefault;
      cfg_q.duty_zero  <= DutyZeroDefault;
      cfg_q.latch_last <= LatchLastDefault;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: decode the pixel word into a job (base slot, run length,
  // colour bits) and hold it in the job register.
  // ---------------------------------------------------------------------------
  job_t dec_job;

  sled_decode u_decode (
    .cfg_i    (cfg_q),
    .opcode_i (pix_i.opcode),
    .row_i    (pix_i.row),
    .column_i (pix_i.column),
    .green_i  (pix_i.green),
    .red_i    (pix_i.red),
    .blue_i   (pix_i.blue),
    .job_o    (dec_job)
  );

  job_t            job_q;
  logic            job_valid_q, job_valid_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pix_accept;
  logic            res_load;
  logic            run_end;

  // Output register may load when empty or being drained this cycle.
  assign res_load   = job_valid_q && (!res_o.valid || res_o.ready);
  assign run_end    = (cnt_q == job_q.last_n);
  // Take a word when idle or while the current job hands over its final result.
  assign pix_i.ready = !job_valid_q || (res_load && run_end);
  assign pix_accept  = pix_i.valid && pix_i.ready;

  always_comb begin
    job_valid_d = job_valid_q;
    if (pix_accept) begin
      job_valid_d = 1'b1;
    end else if (res_load && run_end) begin
      job_valid_d = 1'b0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (res_load) begin
      cnt_d = run_end ? '0 : cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      job_valid_q <= job_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload: load on accept, otherwise advance the colour word one bit per result.
  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      job_q <= dec_job;
    end else if (res_load) begin
      job_q.word <= {job_q.word[BitsPerLed-2:0], 1'b0};
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage: one duty word per cycle from the current job while res_o.ready holds.
  // ---------------------------------------------------------------------------
  res_t res_d, res_q;
  logic res_valid_q, res_valid_d;

  always_comb begin
    res_d.slot_index = job_q.base + {{(SlotW-CntW){1'b0}}, cnt_q};
    res_d.error      = (job_q.kind == KIND_FAULT);
    res_d.last       = run_end;
    case (job_q.kind)
      KIND_PIXEL: res_d.duty = job_q.word[BitsPerLed-1] ? cfg_q.duty_one : cfg_q.duty_zero;
      default:    res_d.duty = '0;  // latch pulse and fault give zero duty
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.slot_index = res_q.slot_index;
  assign res_o.duty       = res_q.duty;
  assign res_o.error      = res_q.error;
  assign res_o.last       = res_q.last;

endmodule

`default_nettype wire

// ----- tb/sled_tb_pkg.sv -----
`default_nettype none

package sled_tb_pkg;
  import sled_pkg::*;

  localparam logic OpPixel = 1'b0;
  localparam logic OpLatch = 1'b1;

  localparam int unsigned MaxRows    = 16;
  localparam int unsigned MaxColumns = 16;

  // Indexes past the register list; writes there must leave the block unchanged.
  localparam int unsigned CfgSpareLo = 5;
  localparam int unsigned CfgSpareHi = 7;

  // Keep the log readable if the block is badly broken.
  localparam int unsigned ReportCap = 40;

  typedef struct packed {
    logic       opcode;
    logic [3:0] row;
    logic [3:0] column;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } pixel_t;

  class sled_scoreboard;
    logic [SizeW-1:0] rows_reg;
    logic [SizeW-1:0] cols_reg;
    logic [DutyW-1:0] duty_one;
    logic [DutyW-1:0] duty_zero;
    logic [6:0]       latch_reg;
    logic [CntW-1:0]  words_of_last_item;
    res_t             duty_words[$];
    int unsigned      errors;
    int unsigned      n_pixels;
    int unsigned      n_latches;
    int unsigned      n_outside;
    int unsigned      n_results;

    function new();
      rows_reg           = RowsDefault;
      cols_reg           = ColsDefault;
      duty_one           = DutyOneDefault;
      duty_zero          = DutyZeroDefault;
      latch_reg          = 7'(LatchLastDefault) + 7'd1;
      words_of_last_item = '0;
    endfunction

    function int unsigned eff_rows();
      return (rows_reg > MaxRows) ? MaxRows : int'(rows_reg);
    endfunction

    function int unsigned eff_cols();
      return (cols_reg > MaxColumns) ? MaxColumns : int'(cols_reg);
    endfunction

    function int unsigned pending();
      return duty_words.size();
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_ROWS:      rows_reg  = data[SizeW-1:0];
        CFG_COLS:      cols_reg  = data[SizeW-1:0];
        CFG_DUTY_ONE:  duty_one  = data;
        CFG_DUTY_ZERO: duty_zero = data;
        CFG_LATCH:     latch_reg = data[6:0];
        default: ;
      endcase
    endfunction

    // Work out every duty word that one accepted pixel word will cause.
    function void note_item(pixel_t p);
      int unsigned rows;
      int unsigned cols;
      int unsigned count;
      int unsigned slot_base;
      int unsigned pos;
      logic [BitsPerLed-1:0] grb;
      res_t w;
      rows = eff_rows();
      cols = eff_cols();
      if (p.opcode == OpLatch) begin
        count = (latch_reg == 0) ? 1 :
                ((latch_reg > MaxLatchSlots) ? MaxLatchSlots : int'(latch_reg));
        slot_base = rows * cols * BitsPerLed;
        for (int unsigned n = 0; n < count; n++) begin
          w.slot_index = SlotW'(slot_base + n);
          w.duty       = '0;
          w.error      = 1'b0;
          w.last       = (n == count - 1);
          duty_words.push_back(w);
        end
        n_latches++;
      end else if (p.row >= rows || p.column >= cols) begin
        w.slot_index = '0;
        w.duty       = '0;
        w.error      = 1'b1;
        w.last       = 1'b1;
        duty_words.push_back(w);
        count = 1;
        n_outside++;
      end else begin
        grb = {p.green, p.red, p.blue};
        // serpentine wiring: odd rows run right to left
        pos = p.row[0] ? (cols - 1 - p.column) : int'(p.column);
        slot_base = (p.row * cols + pos) * BitsPerLed;
        for (int unsigned n = 0; n < BitsPerLed; n++) begin
          w.slot_index = SlotW'(slot_base + n);
          w.duty       = grb[BitsPerLed-1-n] ? duty_one : duty_zero;
          w.error      = 1'b0;
          w.last       = (n == BitsPerLed - 1);
          duty_words.push_back(w);
        end
        count = BitsPerLed;
        n_pixels++;
      end
      words_of_last_item = CntW'(count);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= ReportCap) $display("mismatch: %s", msg);
    endtask

    task check(res_t got);
      res_t want;
      n_results++;
      if (duty_words.size() == 0) begin
        report($sformatf("unexpected word slot %0d duty %0d error %0b last %0b",
                         got.slot_index, got.duty, got.error, got.last));
        return;
      end
      want = duty_words.pop_front();
      if (got.slot_index !== want.slot_index)
        report($sformatf("slot_index %0d, want %0d", got.slot_index, want.slot_index));
      if (got.duty !== want.duty)
        report($sformatf("duty %0d at slot %0d, want %0d",
                         got.duty, want.slot_index, want.duty));
      if (got.error !== want.error)
        report($sformatf("error %0b at slot %0d, want %0b",
                         got.error, want.slot_index, want.error));
      if (got.last !== want.last)
        report($sformatf("last %0b at slot %0d, want %0b",
                         got.last, want.slot_index, want.last));
    endtask
  endclass

endpackage

`default_nettype wire

// ----- tb/serpentine_led_bit_encoder_top_tb.sv -----
`default_nettype none

module serpentine_led_bit_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sled_pkg::*;
  import sled_tb_pkg::*;

  // Cycles to let the block settle once the last duty word is in; the first
  // word of an item passes the job register, then the result register.
  localparam int unsigned SettleCycles = 4;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned n_settings = 0;

  sled_scoreboard sb;
  pixel_t         seen_pixel;
  res_t           seen_word;

  sled_pix_if pix_if ();
  sled_cfg_if cfg_if ();
  sled_res_if res_if ();

  serpentine_led_bit_encoder_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // 4 ns period: two halves of 2 ns.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver side: drop ready at random, on the falling edge only, so that the
  // block sees a settled value at every rising edge.
  always @(negedge clk_i) begin
    res_if.ready = ($urandom_range(99) >= stall_pct);
  end

  // One observer for all three channels. Note inputs and register writes
  // before checking results so that the order within a step never matters.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_register(cfg_if.index, cfg_if.data);
      end
      if (pix_if.valid && pix_if.ready) begin
        seen_pixel.opcode = pix_if.opcode;
        seen_pixel.row    = pix_if.row;
        seen_pixel.column = pix_if.column;
        seen_pixel.green  = pix_if.green;
        seen_pixel.red    = pix_if.red;
        seen_pixel.blue   = pix_if.blue;
        sb.note_item(seen_pixel);
      end
      if (res_if.valid && res_if.ready) begin
        seen_word.slot_index = res_if.slot_index;
        seen_word.duty       = res_if.duty;
        seen_word.error      = res_if.error;
        seen_word.last       = res_if.last;
        sb.check(seen_word);
      end
    end
  end

  task automatic set_idle(idle_mode_e mode);
    idle_pct  = (mode == IDLE_SENDER)   ? 74 : ((mode == IDLE_BOTH) ? 21 : 0);
    stall_pct = (mode == IDLE_RECEIVER) ? 74 : ((mode == IDLE_BOTH) ? 21 : 0);
  endtask

  // Offer one pixel word and hold it until the block takes it. Valid is left
  // high afterwards so that back-to-back words need no second assignment.
  task automatic send_word(pixel_t p);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      pix_if.valid = 1'b0;
    end
    @(negedge clk_i);
    pix_if.valid  = 1'b1;
    pix_if.opcode = p.opcode;
    pix_if.row    = p.row;
    pix_if.column = p.column;
    pix_if.green  = p.green;
    pix_if.red    = p.red;
    pix_if.blue   = p.blue;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  // Drop valid and wait until every expected duty word has come out.
  task automatic hold_and_drain();
    @(negedge clk_i);
    pix_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Write the whole register set; call only with the block idle.
  task automatic apply_setting(logic [7:0] rows, logic [7:0] cols, logic [7:0] d_one,
                               logic [7:0] d_zero, logic [7:0] latch);
    write_register(CFG_ROWS, rows);
    write_register(CFG_COLS, cols);
    write_register(CFG_DUTY_ONE, d_one);
    write_register(CFG_DUTY_ZERO, d_zero);
    write_register(CFG_LATCH, latch);
    n_settings++;
  endtask

  function automatic pixel_t make_item(logic op, logic [3:0] r, logic [3:0] c,
                                       logic [23:0] grb);
    pixel_t p;
    p.opcode = op;
    p.row    = r;
    p.column = c;
    {p.green, p.red, p.blue} = grb;
    return p;
  endfunction

  // Mostly well-formed pixels inside the matrix, with latch pulses and raw
  // noise (any row, column or opcode) mixed in.
  function automatic pixel_t random_item();
    pixel_t      p;
    logic [63:0] raw;
    int unsigned roll;
    int unsigned rows;
    int unsigned cols;
    rows = sb.eff_rows();
    cols = sb.eff_cols();
    roll = $urandom_range(99);
    raw  = {$urandom, $urandom};
    p    = raw[$bits(pixel_t)-1:0];
    if (roll < 12) begin
      p.opcode = OpLatch;
    end else if (roll >= 30 && rows != 0 && cols != 0) begin
      p.opcode = OpPixel;
      p.row    = 4'($urandom_range(rows - 1));
      p.column = 4'($urandom_range(cols - 1));
    end
    return p;
  endfunction

  // Random words under the current setting, with one full drain before a randomly
  // chosen word, then drain and settle ready for the next register writes.
  task automatic run_random(int unsigned n_items);
    int unsigned pause_at;
    pause_at = $urandom_range(n_items - 1);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == pause_at) hold_and_drain();
      send_word(random_item());
    end
    hold_and_drain();
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    sb = new();
    rst_ni        = 1'b0;
    pix_if.valid  = 1'b0;
    pix_if.opcode = OpPixel;
    pix_if.row    = '0;
    pix_if.column = '0;
    pix_if.green  = '0;
    pix_if.red    = '0;
    pix_if.blue   = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_ROWS;
    cfg_if.data   = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults (8 x 8, duties 60/30, 50 latch slots), no idling.
    set_idle(IDLE_NONE);
    send_word(make_item(OpPixel, 4'd0, 4'd0, 24'hFFFFFF));
    send_word(make_item(OpPixel, 4'd0, 4'd0, 24'h000000));
    send_word(make_item(OpPixel, 4'd0, 4'd7, 24'h8001AA));
    // odd rows run backwards
    send_word(make_item(OpPixel, 4'd1, 4'd0, 24'h00FF55));
    send_word(make_item(OpPixel, 4'd1, 4'd7, 24'hC3A50F));
    send_word(make_item(OpPixel, 4'd7, 4'd7, 24'h123456));
    send_word(make_item(OpPixel, 4'd7, 4'd0, 24'hFEDCBA));
    send_word(make_item(OpLatch, 4'd0, 4'd0, 24'h000000));
    // row, column and both past the configured size
    send_word(make_item(OpPixel, 4'd8, 4'd0, 24'hFFFFFF));
    send_word(make_item(OpPixel, 4'd0, 4'd8, 24'hFFFFFF));
    send_word(make_item(OpPixel, 4'd15, 4'd15, 24'hFFFFFF));
    // latch pulse ignores the pixel fields
    send_word(make_item(OpLatch, 4'd15, 4'd15, 24'hFFFFFF));
    send_word(make_item(OpPixel, 4'd6, 4'd3, 24'h5A5A5A));
    send_word(make_item(OpLatch, 4'd9, 4'd2, 24'hA5A5A5));
    run_random(30);

    // Largest matrix, extreme duties, longest latch; upper data bits set.
    apply_setting(8'hF0, 8'd16, 8'd255, 8'd0, 8'd64);
    set_idle(IDLE_SENDER);
    send_word(make_item(OpPixel, 4'd15, 4'd15, 24'hFFFFFF));
    send_word(make_item(OpPixel, 4'd15, 4'd0, 24'h0F0F0F));
    send_word(make_item(OpPixel, 4'd14, 4'd15, 24'hF00F00));
    send_word(make_item(OpLatch, 4'd0, 4'd0, 24'h000000));
    run_random(35);

    // Single LED, duties swapped over, shortest latch.
    apply_setting(8'd1, 8'd1, 8'd0, 8'd255, 8'd1);
    set_idle(IDLE_RECEIVER);
    run_random(35);

    // Rows saturate, no columns: every pixel outside, latch of zero means one.
    apply_setting(8'h1F, 8'd0, 8'hA5, 8'h5A, 8'd0);
    set_idle(IDLE_BOTH);
    run_random(30);

    // No rows, latch count above the maximum clamps to 64.
    apply_setting(8'd0, 8'hEF, 8'h81, 8'h7E, 8'hFF);
    set_idle(IDLE_NONE);
    run_random(30);

    // Random sizes inside the legal range; spare indexes must be ignored.
    apply_setting(8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)), 8'($urandom),
                  8'($urandom), 8'($urandom_range(1, 64)));
    for (int unsigned k = CfgSpareLo; k <= CfgSpareHi; k++) begin
      write_register(CfgIdxW'(k), 8'($urandom));
    end
    set_idle(IDLE_SENDER);
    run_random(30);

    // Whole random data bytes for every register.
    apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    set_idle(IDLE_RECEIVER);
    run_random(30);

    hold_and_drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d pixels, %0d latch pulses and %0d out-of-range words",
             sb.n_pixels, sb.n_latches, sb.n_outside);
    $display("%0d duty words checked over %0d register settings, %0d mismatches",
             sb.n_results, n_settings + 1, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[serpentine_led_bit_encoder_top] OK");
    end else begin
      $display("[serpentine_led_bit_encoder_top] ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4000000;
    $display("timeout with %0d duty words outstanding", sb.pending());
    $display("[serpentine_led_bit_encoder_top] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
